>>> src/flcd_pkg.sv
// ----------------------------------------------------------------------------
// Fixed-length code decoder package
// Shared item kinds, result flags and fixed field widths.
// ----------------------------------------------------------------------------
package flcd_pkg;

  localparam int SYM_BITS      = 8;
  localparam int BYTE_BITS     = 8;
  localparam int CODE_IN_BITS  = 16;
  localparam int LEN_CFG_BITS  = 5;

  localparam logic [LEN_CFG_BITS-1:0] CODE_LENGTH_RESET = 5'd8;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_DATA = 1'b1
  } op_t;

  typedef struct packed {
    logic end_marker;
    logic last;
  } res_flags_t;

endpackage

>>> src/flcd_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered, read-first.
// ----------------------------------------------------------------------------
module flcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/flcd_front.sv
// ----------------------------------------------------------------------------
// Fixed-length code decoder intake
// Accepts input items, classifies them and queues them for the decode engine.
// ----------------------------------------------------------------------------
module flcd_front #(
  parameter int CODE_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 hold,
  input  logic                                 push,
  output logic                                 full,
  input  logic                                 op,
  input  logic [flcd_pkg::CODE_IN_BITS-1:0]    load_code,
  input  logic [flcd_pkg::SYM_BITS-1:0]        load_symbol,
  input  logic [flcd_pkg::BYTE_BITS-1:0]       data_byte,
  output logic                                 cmd_valid,
  input  logic                                 cmd_ready,
  output flcd_pkg::op_t                        cmd_op,
  output logic [CODE_BITS-1:0]                 cmd_code,
  output logic [flcd_pkg::BYTE_BITS-1:0]       cmd_value
);

  import flcd_pkg::*;

  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);
  localparam int CNTW  = $clog2(DEPTH + 1);

  op_t                  q_op    [DEPTH];
  logic [CODE_BITS-1:0] q_code  [DEPTH];
  logic [BYTE_BITS-1:0] q_value [DEPTH];
  logic [PW-1:0]        wr_ptr;
  logic [PW-1:0]        rd_ptr;
  logic [CNTW-1:0]      count;
  logic [CNTW-1:0]      count_next;
  logic                 accept;
  logic                 take;
  op_t                  in_kind;

  assign full      = hold || (count == CNTW'(DEPTH));
  assign accept    = push && !full;
  assign cmd_valid = (count != '0);
  assign take      = cmd_valid && cmd_ready;
  assign in_kind   = op_t'(op);

  assign cmd_op    = q_op[rd_ptr];
  assign cmd_code  = q_code[rd_ptr];
  assign cmd_value = q_value[rd_ptr];

  always_comb begin
    case ({accept, take})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (accept) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (take) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_op[wr_ptr]    <= in_kind;
      q_code[wr_ptr]  <= CODE_BITS'(load_code);
      q_value[wr_ptr] <= (in_kind == OP_DATA) ? data_byte : load_symbol;
    end
  end

endmodule

>>> src/flcd_back.sv
// ----------------------------------------------------------------------------
// Fixed-length code decoder engine
// Unpacks data bytes into codewords, looks them up in the code table and
// writes table entries; clears the table after reset.
// ----------------------------------------------------------------------------
module flcd_back #(
  parameter int CODE_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [flcd_pkg::LEN_CFG_BITS-1:0]    cfg_data,
  input  logic                                 cmd_valid,
  output logic                                 cmd_ready,
  input  flcd_pkg::op_t                        cmd_op,
  input  logic [CODE_BITS-1:0]                 cmd_code,
  input  logic [flcd_pkg::BYTE_BITS-1:0]       cmd_value,
  output logic                                 clearing,
  input  logic                                 room,
  output logic                                 res_valid,
  output logic [flcd_pkg::SYM_BITS-1:0]        res_symbol,
  output flcd_pkg::res_flags_t                 res_flags
);

  import flcd_pkg::*;

  localparam int TABLE_DEPTH = 1 << CODE_BITS;
  localparam int LW0         = $clog2(CODE_BITS + 1);
  localparam int CW          = (LW0 > 4) ? LW0 : 4;

  function automatic logic [CW-1:0] eff_len(input logic [LEN_CFG_BITS-1:0] v);
    logic [CW-1:0] n;
    if (v == '0) begin
      n = CW'(1);
    end else if (int'(v) > CODE_BITS) begin
      n = CW'(CODE_BITS);
    end else begin
      n = CW'(v);
    end
    return n;
  endfunction

  logic [CODE_BITS-1:0]   acc;
  logic [CW-1:0]          cnt;
  logic [CW-1:0]          len;
  logic [BYTE_BITS-1:0]   byte_sh;
  logic [3:0]             rem;
  logic                   active;
  logic                   ended;
  logic [CODE_BITS-1:0]   clr_addr;
  res_flags_t             rd_flags;
  logic [SYM_BITS-1:0]    rdata;

  logic [CODE_BITS-1:0]   ones;
  logic [CW-1:0]          need;
  logic [3:0]             take;
  logic [CODE_BITS+7:0]   shifted;
  logic [CODE_BITS-1:0]   acc_sh;
  logic [BYTE_BITS-1:0]   byte_nx;
  logic [3:0]             rem_nx;
  logic [CW-1:0]          cnt_nx;
  logic [BYTE_BITS-1:0]   left8;
  logic                   complete;
  logic                   is_end;
  logic                   short_rest;
  logic                   step_go;
  logic                   step_done;
  logic                   cmd_fire;
  logic                   ram_we;
  logic [CODE_BITS-1:0]   ram_waddr;
  logic [SYM_BITS-1:0]    ram_wdata;

  assign ones       = ~({CODE_BITS{1'b1}} << len);
  assign need       = len - cnt;
  assign take       = (CW'(rem) < need) ? rem : need[3:0];
  assign shifted    = {acc, byte_sh} << take;
  assign acc_sh     = shifted[CODE_BITS+7:8];
  assign byte_nx    = shifted[7:0];
  assign rem_nx     = rem - take;
  assign cnt_nx     = cnt + CW'(take);
  assign left8      = byte_nx >> (4'd8 - rem_nx);
  assign complete   = (cnt_nx == len);
  assign is_end     = complete && (acc_sh == ones);
  assign short_rest = (CW'(rem_nx) < len);

  assign step_go   = active && (!complete || room);
  assign step_done = step_go && (!complete || is_end || short_rest);
  assign cmd_ready = !clearing && (!active || step_done);
  assign cmd_fire  = cmd_valid && cmd_ready;

  assign ram_we    = clearing || (cmd_fire && (cmd_op == OP_LOAD));
  assign ram_waddr = clearing ? clr_addr : cmd_code;
  assign ram_wdata = clearing ? '0 : cmd_value;

  assign res_symbol = res_flags.end_marker ? '0 : rdata;
  assign res_flags  = rd_flags;

  flcd_ram #(
    .WIDTH (SYM_BITS),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (step_go && complete),
    .raddr (acc_sh),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      cnt       <= '0;
      len       <= eff_len(CODE_LENGTH_RESET);
      byte_sh   <= '0;
      rem       <= '0;
      active    <= 1'b0;
      ended     <= 1'b0;
      clearing  <= 1'b1;
      clr_addr  <= '0;
      res_valid <= 1'b0;
      rd_flags  <= '0;
    end else begin
      res_valid <= step_go && complete;
      rd_flags  <= '{end_marker: is_end, last: is_end || short_rest};

      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == {CODE_BITS{1'b1}}) begin
          clearing <= 1'b0;
        end
      end

      if (cfg_we) begin
        len <= eff_len(cfg_data);
        acc <= '0;
        cnt <= '0;
      end else if (step_go) begin
        if (is_end) begin
          ended  <= 1'b1;
          acc    <= '0;
          cnt    <= '0;
        end else if (complete && !short_rest) begin
          acc     <= '0;
          cnt     <= '0;
          byte_sh <= byte_nx;
          rem     <= rem_nx;
        end else if (complete) begin
          acc    <= CODE_BITS'(left8);
          cnt    <= CW'(rem_nx);
        end else begin
          acc    <= acc_sh;
          cnt    <= cnt_nx;
        end
      end

      if (cmd_fire && (cmd_op == OP_DATA) && !ended && !(step_go && is_end)) begin
        active  <= 1'b1;
        byte_sh <= cmd_value;
        rem     <= 4'd8;
      end else if (!cfg_we && step_done) begin
        active  <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  a_cnt_in_range: assert property (@(posedge clk) disable iff (rst)
    cnt < len || (active && cnt == len))
    else $error("bit count beyond code length");

  a_end_sets_flag: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_flags.end_marker |-> ended)
    else $error("end result without stream end");

  a_no_work_in_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !active && !cmd_ready && !res_valid)
    else $error("decode activity during table clear");
`endif

endmodule

>>> src/flcd_out.sv
// ----------------------------------------------------------------------------
// Fixed-length code decoder result queue
// Buffers decoded results until they are popped.
// ----------------------------------------------------------------------------
module flcd_out (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            res_valid,
  input  logic [flcd_pkg::SYM_BITS-1:0]   res_symbol,
  input  flcd_pkg::res_flags_t            res_flags,
  output logic                            room,
  output logic                            empty,
  input  logic                            pop,
  output logic [flcd_pkg::SYM_BITS-1:0]   symbol,
  output logic                            end_marker,
  output logic                            last
);

  import flcd_pkg::*;

  localparam int DEPTH = 4;
  localparam int PW    = $clog2(DEPTH);
  localparam int CNTW  = $clog2(DEPTH + 1);

  logic [SYM_BITS-1:0] q_sym [DEPTH];
  res_flags_t          q_flg [DEPTH];
  logic [PW-1:0]       wr_ptr;
  logic [PW-1:0]       rd_ptr;
  logic [CNTW-1:0]     count;
  logic [CNTW-1:0]     count_next;
  logic                take;
  res_flags_t          head_flags;

  assign empty      = (count == '0);
  assign take       = pop && !empty;
  assign room       = (count + CNTW'(res_valid)) < CNTW'(DEPTH);
  assign head_flags = q_flg[rd_ptr];
  assign symbol     = q_sym[rd_ptr];
  assign end_marker = head_flags.end_marker;
  assign last       = head_flags.last;

  always_comb begin
    case ({res_valid, take})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (res_valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (take) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      q_sym[wr_ptr] <= res_symbol;
      q_flg[wr_ptr] <= res_flags;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> count < CNTW'(DEPTH))
    else $error("result queue overflow");
`endif

endmodule

>>> src/fixed_length_code_decoder.sv
// ----------------------------------------------------------------------------
// Fixed-length code decoder
// Load items fill a code table of 2^CODE_BITS_MAX symbols; data bytes are
// unpacked MSB first into fixed-length codewords that are looked up in it.
// ----------------------------------------------------------------------------
// After reset the table is swept to zero, one entry per cycle, through all
// 2^CODE_BITS_MAX entries (65536 at the default); full stays high meanwhile,
// while code_length writes are still taken. Afterwards the decode engine
// holds each data byte until no further whole codeword can be completed from
// its bits, and takes no new item before then; it produces at most one table
// lookup per cycle through the single read port of the table, and stalls
// while the result queue has no room. The all-ones code ends the stream: it
// yields one result with end_marker set, and later data bytes are dropped
// until reset. Writing code_length drops any partial codeword.
module fixed_length_code_decoder #(
  parameter int CODE_BITS_MAX = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  output logic                                 full,
  input  logic                                 op,
  input  logic [flcd_pkg::CODE_IN_BITS-1:0]    load_code,
  input  logic [flcd_pkg::SYM_BITS-1:0]        load_symbol,
  input  logic [flcd_pkg::BYTE_BITS-1:0]       data_byte,
  input  logic                                 code_length_we,
  input  logic [flcd_pkg::LEN_CFG_BITS-1:0]    code_length,
  output logic                                 empty,
  input  logic                                 pop,
  output logic [flcd_pkg::SYM_BITS-1:0]        symbol,
  output logic                                 end_marker,
  output logic                                 last
);

  import flcd_pkg::*;

  logic                     clearing;
  logic                     cmd_valid;
  logic                     cmd_ready;
  op_t                      cmd_op;
  logic [CODE_BITS_MAX-1:0] cmd_code;
  logic [BYTE_BITS-1:0]     cmd_value;
  logic                     room;
  logic                     res_valid;
  logic [SYM_BITS-1:0]      res_symbol;
  res_flags_t               res_flags;

  flcd_front #(
    .CODE_BITS (CODE_BITS_MAX)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .hold        (clearing),
    .push        (push),
    .full        (full),
    .op          (op),
    .load_code   (load_code),
    .load_symbol (load_symbol),
    .data_byte   (data_byte),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .cmd_op      (cmd_op),
    .cmd_code    (cmd_code),
    .cmd_value   (cmd_value)
  );

  flcd_back #(
    .CODE_BITS (CODE_BITS_MAX)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (code_length_we),
    .cfg_data   (code_length),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd_op     (cmd_op),
    .cmd_code   (cmd_code),
    .cmd_value  (cmd_value),
    .clearing   (clearing),
    .room       (room),
    .res_valid  (res_valid),
    .res_symbol (res_symbol),
    .res_flags  (res_flags)
  );

  flcd_out u_out (
    .clk        (clk),
    .rst        (rst),
    .res_valid  (res_valid),
    .res_symbol (res_symbol),
    .res_flags  (res_flags),
    .room       (room),
    .empty      (empty),
    .pop        (pop),
    .symbol     (symbol),
    .end_marker (end_marker),
    .last       (last)
  );

endmodule
